@@ src/vgf_pkg.sv @@
// vgf_pkg: constants, codes, table entry type and key ordering for the
// voxel grid first point filter. No dependencies.
package vgf_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 31;
  localparam int DIV_CNT_W = $clog2(COORD_W);

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] ST_KEPT     = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_PAST_END = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  localparam logic [SIZE_W-1:0] VOXEL_SIZE_RESET = SIZE_W'(65536);

  typedef struct packed {
    logic signed [COORD_W-1:0] kx;
    logic signed [COORD_W-1:0] ky;
    logic signed [COORD_W-1:0] kz;
  } key_t;

  typedef struct packed {
    key_t                      key;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } entry_t;

  // a sorts below b: x, then y, then z, signed
  function automatic logic key_less(key_t a, key_t b);
    logic r;
    if (a.kx != b.kx) r = (a.kx < b.kx);
    else if (a.ky != b.ky) r = (a.ky < b.ky);
    else r = (a.kz < b.kz);
    return r;
  endfunction

endpackage

@@ src/vgf_in_if.sv @@
// vgf_in_if: input channel of the filter, valid/ready with action and point.
// Depends on vgf_pkg.
interface vgf_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic signed [vgf_pkg::COORD_W-1:0] point_x;
  logic signed [vgf_pkg::COORD_W-1:0] point_y;
  logic signed [vgf_pkg::COORD_W-1:0] point_z;
  modport source (output valid, action, point_x, point_y, point_z, input ready);
  modport sink   (input valid, action, point_x, point_y, point_z, output ready);
endinterface

@@ src/vgf_out_if.sv @@
// vgf_out_if: result channel of the filter, valid/ready with status and point.
// Depends on vgf_pkg.
interface vgf_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic signed [vgf_pkg::COORD_W-1:0] out_x;
  logic signed [vgf_pkg::COORD_W-1:0] out_y;
  logic signed [vgf_pkg::COORD_W-1:0] out_z;
  logic [vgf_pkg::CNT_W-1:0]          kept_count;
  logic                               last_kept;
  modport source (output valid, status, out_x, out_y, out_z, kept_count, last_kept,
                  input ready);
  modport sink   (input valid, status, out_x, out_y, out_z, kept_count, last_kept,
                  output ready);
endinterface

@@ src/voxel_grid_first_point_filter.sv @@
// voxel_grid_first_point_filter: one item at a time. An add runs a bit-serial floor
// division (three axes in parallel), a binary search with a read and a compare state
// per step over the sorted table memory, a read and a write state per entry moved on
// insert, then the output state. The single-port table memory sets the insert cost.
// Synchronous active-low reset clears count, read pointer, voxel size (to 1.0) and
// control; the table needs no sweep.
module voxel_grid_first_point_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  vgf_in_if.sink                     in_ch,
  vgf_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [vgf_pkg::SIZE_W-1:0] cfg_wdata
);
  import vgf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_FIX = 4'd2, S_BS_RD = 4'd3,
                         S_BS_CMP = 4'd4, S_CHK_RD = 4'd5, S_CHK_CMP = 4'd6,
                         S_SH_RD = 4'd7, S_SH_WR = 4'd8, S_INS = 4'd9,
                         S_RD_WAIT = 4'd10, S_OUT = 4'd11;

  logic [3:0]              state_r, state_nxt;
  logic [SIZE_W-1:0]       voxel_size_r;
  logic [CNT_W-1:0]        count_r, rp_r, lo_r, hi_r, idx_r;
  logic [ADDR_W-1:0]       mid_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;
  logic [COORD_W-1:0]      px_r, py_r, pz_r;
  logic [COORD_W-1:0]      q_r [3];
  logic [SIZE_W-1:0]       rem_r [3];
  logic [2:0]              neg_r;
  key_t                    key_r;
  logic [2:0]              res_status_r;
  logic [COORD_W-1:0]      res_x_r, res_y_r, res_z_r;
  logic                    res_last_r;
  logic                    out_valid_r;

  // table memory
  entry_t                  mem [CAPACITY];
  entry_t                  rdata_r;
  logic                    rd_en, wr_en;
  logic [ADDR_W-1:0]       raddr, waddr;
  entry_t                  wdata;

  logic [SIZE_W-1:0]       den;
  logic [CNT_W:0]          mid_sum;
  logic                    in_xfer;

  assign den      = (voxel_size_r == '0) ? SIZE_W'(1) : voxel_size_r;
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  // memory address and enable selection
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = idx_r[ADDR_W-1:0];
    wdata = rdata_r;
    case (state_r)
      S_IDLE: begin
        rd_en = in_xfer && (in_ch.action == ACT_READ);
        raddr = rp_r[ADDR_W-1:0];
      end
      S_BS_RD: begin
        rd_en = (lo_r < hi_r);
        raddr = mid_sum[ADDR_W:1];
      end
      S_CHK_RD: begin
        rd_en = (lo_r < count_r);
        raddr = lo_r[ADDR_W-1:0];
      end
      S_SH_RD: begin
        rd_en = 1'b1;
        raddr = ADDR_W'(idx_r - CNT_W'(1));
      end
      S_SH_WR: wr_en = 1'b1;
      S_INS: begin
        wr_en = 1'b1;
        waddr = lo_r[ADDR_W-1:0];
        wdata = '{key: key_r, px: px_r, py: py_r, pz: pz_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[raddr];
    if (wr_en) mem[waddr] <= wdata;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.action == ACT_ADD) state_nxt = S_DIV;
          else if (in_ch.action == ACT_READ && rp_r < count_r) state_nxt = S_RD_WAIT;
          else state_nxt = S_OUT;
        end
      end
      S_DIV:     if (div_cnt_r == DIV_CNT_W'(COORD_W - 1)) state_nxt = S_FIX;
      S_FIX:     state_nxt = S_BS_RD;
      S_BS_RD:   state_nxt = (lo_r < hi_r) ? S_BS_CMP : S_CHK_RD;
      S_BS_CMP:  state_nxt = S_BS_RD;
      S_CHK_RD: begin
        if (lo_r < count_r) state_nxt = S_CHK_CMP;
        else if (count_r >= CNT_W'(CAPACITY)) state_nxt = S_OUT;
        else state_nxt = (count_r == lo_r) ? S_INS : S_SH_RD;
      end
      S_CHK_CMP: begin
        if (rdata_r.key == key_r || count_r >= CNT_W'(CAPACITY)) state_nxt = S_OUT;
        else state_nxt = S_SH_RD;
      end
      S_SH_RD:   state_nxt = S_SH_WR;
      S_SH_WR:   state_nxt = (idx_r - CNT_W'(1) == lo_r) ? S_INS : S_SH_RD;
      S_INS:     state_nxt = S_OUT;
      S_RD_WAIT: state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      voxel_size_r <= VOXEL_SIZE_RESET;
      count_r      <= '0;
      rp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) voxel_size_r <= cfg_wdata;
      if (state_r == S_IDLE && in_xfer && in_ch.action == ACT_CLEAR) begin
        count_r <= '0;
        rp_r    <= '0;
      end
      if (state_r == S_INS) count_r <= count_r + CNT_W'(1);
      if (state_r == S_RD_WAIT) rp_r <= rp_r + CNT_W'(1);
      // result register: load a new result, or empty it on a transfer
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers: divider, search bounds, result
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          px_r <= in_ch.point_x;
          py_r <= in_ch.point_y;
          pz_r <= in_ch.point_z;
          neg_r <= {in_ch.point_z[COORD_W-1], in_ch.point_y[COORD_W-1],
                    in_ch.point_x[COORD_W-1]};
          q_r[0] <= in_ch.point_x[COORD_W-1] ? -in_ch.point_x : in_ch.point_x;
          q_r[1] <= in_ch.point_y[COORD_W-1] ? -in_ch.point_y : in_ch.point_y;
          q_r[2] <= in_ch.point_z[COORD_W-1] ? -in_ch.point_z : in_ch.point_z;
          for (int a = 0; a < 3; a++) rem_r[a] <= '0;
          div_cnt_r    <= '0;
          res_x_r      <= '0;
          res_y_r      <= '0;
          res_z_r      <= '0;
          res_last_r   <= 1'b0;
          res_status_r <= (in_ch.action == ACT_CLEAR) ? ST_CLEARED : ST_PAST_END;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle on each axis
        for (int a = 0; a < 3; a++) begin
          if ({rem_r[a], q_r[a][COORD_W-1]} >= {1'b0, den}) begin
            rem_r[a] <= SIZE_W'({rem_r[a], q_r[a][COORD_W-1]} - {1'b0, den});
            q_r[a]   <= {q_r[a][COORD_W-2:0], 1'b1};
          end else begin
            rem_r[a] <= SIZE_W'({rem_r[a], q_r[a][COORD_W-1]});
            q_r[a]   <= {q_r[a][COORD_W-2:0], 1'b0};
          end
        end
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      S_FIX: begin
        // floor for negative numerators: -q, or -q-1 when inexact
        key_r.kx <= !neg_r[0] ? q_r[0] : ((rem_r[0] != '0) ? ~q_r[0] : -q_r[0]);
        key_r.ky <= !neg_r[1] ? q_r[1] : ((rem_r[1] != '0) ? ~q_r[1] : -q_r[1]);
        key_r.kz <= !neg_r[2] ? q_r[2] : ((rem_r[2] != '0) ? ~q_r[2] : -q_r[2]);
        lo_r <= '0;
        hi_r <= count_r;
      end
      S_BS_RD: mid_r <= mid_sum[ADDR_W:1];
      S_BS_CMP: begin
        if (key_less(rdata_r.key, key_r)) lo_r <= CNT_W'(mid_r) + CNT_W'(1);
        else hi_r <= CNT_W'(mid_r);
      end
      S_CHK_RD: begin
        idx_r        <= count_r;
        res_status_r <= (count_r >= CNT_W'(CAPACITY)) ? ST_FULL : ST_KEPT;
      end
      S_CHK_CMP: begin
        if (rdata_r.key == key_r) res_status_r <= ST_DUP;
      end
      S_SH_WR: idx_r <= idx_r - CNT_W'(1);
      S_RD_WAIT: begin
        res_status_r <= ST_READ;
        res_x_r      <= rdata_r.px;
        res_y_r      <= rdata_r.py;
        res_z_r      <= rdata_r.pz;
        res_last_r   <= (rp_r + CNT_W'(1) == count_r);
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_ch.status     <= res_status_r;
          out_ch.out_x      <= res_x_r;
          out_ch.out_y      <= res_y_r;
          out_ch.out_z      <= res_z_r;
          out_ch.kept_count <= count_r;
          out_ch.last_kept  <= res_last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid_r;

endmodule

@@ src/vgf_checker.sv @@
// vgf_checker: port-level assertions for the voxel grid first point filter,
// bound to the top level. Depends on vgf_pkg.
module vgf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 status,
  input logic [31:0]                out_x,
  input logic [31:0]                out_y,
  input logic [31:0]                out_z,
  input logic [vgf_pkg::CNT_W-1:0]  kept_count,
  input logic                       last_kept
);
  import vgf_pkg::*;

  // a waiting result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kept_count <= CNT_W'(CAPACITY))
    else $error("kept count beyond capacity");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_READ |-> out_x == '0 && out_y == '0 && out_z == '0
      && !last_kept)
    else $error("coordinates on a non-read result");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_CLEARED)
    else $error("unknown status code");

endmodule

bind voxel_grid_first_point_filter vgf_checker u_vgf_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .out_x(out_ch.out_x), .out_y(out_ch.out_y),
  .out_z(out_ch.out_z), .kept_count(out_ch.kept_count), .last_kept(out_ch.last_kept)
);

@@ bench/tb_voxel_grid_first_point_filter.sv @@
// tb_voxel_grid_first_point_filter: self-checking bench for the voxel grid filter,
// a directed table then random traffic over several voxel sizes, checked by a predictor.
// Depends on vgf_pkg, vgf_in_if, vgf_out_if and voxel_grid_first_point_filter.
module tb_voxel_grid_first_point_filter;
  import vgf_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]                status;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } voxel_result_t;

  typedef struct {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    bit                        typed;
    logic [2:0]                status;
    logic [CNT_W-1:0]          count;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  vgf_in_if  in_ch ();
  vgf_out_if out_ch ();

  voxel_grid_first_point_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  entry_t           voxel_table [CAPACITY];
  int unsigned      held_count;
  int unsigned      walk_pos;
  logic [SIZE_W-1:0] edge_len;

  voxel_result_t    pending_results [$];
  int               mismatches;
  int               results_seen;
  int               items_sent;
  int               sizes_used;
  bit               idle_on;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // exact floor division of one coordinate by the voxel edge
  function automatic logic signed [COORD_W-1:0] voxel_key(logic signed [COORD_W-1:0] c);
    longint num;
    longint den;
    longint q;
    num = c;
    den = (edge_len == 0) ? 1 : longint'(edge_len);
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q[COORD_W-1:0];
  endfunction

  // -1 below, 0 equal, 1 above: x, then y, then z, signed
  function automatic int key_cmp(key_t a, key_t b);
    if (a.kx != b.kx) return (a.kx < b.kx) ? -1 : 1;
    if (a.ky != b.ky) return (a.ky < b.ky) ? -1 : 1;
    if (a.kz != b.kz) return (a.kz < b.kz) ? -1 : 1;
    return 0;
  endfunction

  function automatic voxel_result_t filter_step(logic [1:0] act, logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic signed [COORD_W-1:0] z);
    voxel_result_t r;
    key_t k;
    int unsigned pos;
    int ord;
    r = '{status: ST_PAST_END, x: '0, y: '0, z: '0, count: '0, last: 1'b0};
    case (act)
      ACT_ADD: begin
        k.kx = voxel_key(x);
        k.ky = voxel_key(y);
        k.kz = voxel_key(z);
        pos = 0;
        ord = 1;
        while (pos < held_count) begin
          ord = key_cmp(voxel_table[pos].key, k);
          if (ord >= 0) break;
          pos++;
        end
        if (pos < held_count && ord == 0) r.status = ST_DUP;
        else if (held_count >= CAPACITY) r.status = ST_FULL;
        else begin
          for (int unsigned i = held_count; i > pos; i--) voxel_table[i] = voxel_table[i-1];
          voxel_table[pos] = '{key: k, px: x, py: y, pz: z};
          held_count++;
          r.status = ST_KEPT;
        end
      end
      ACT_READ: begin
        if (walk_pos < held_count) begin
          r.x = voxel_table[walk_pos].px;
          r.y = voxel_table[walk_pos].py;
          r.z = voxel_table[walk_pos].pz;
          r.last = (walk_pos + 1 == held_count);
          walk_pos++;
          r.status = ST_READ;
        end
      end
      ACT_CLEAR: begin
        held_count = 0;
        walk_pos = 0;
        r.status = ST_CLEARED;
      end
      default: r.status = ST_PAST_END;
    endcase
    r.count = held_count[CNT_W-1:0];
    return r;
  endfunction

  // one input transfer, with random idle cycles ahead of it while idling is on
  task automatic send_item(directed_row_t row);
    voxel_result_t r;
    while (idle_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= row.action;
    in_ch.point_x <= row.x;
    in_ch.point_y <= row.y;
    in_ch.point_z <= row.z;
    do @(posedge clk); while (!in_ch.ready);
    r = filter_step(row.action, row.x, row.y, row.z);
    if (row.typed) begin
      r.status = row.status;
      r.count  = row.count;
    end
    pending_results.insert(pending_results.size(), r);
    items_sent++;
  endtask

  task automatic add_point(logic [1:0] act, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    directed_row_t row;
    row = '{action: act, x: x, y: y, z: z, typed: 1'b0, status: '0, count: '0};
    send_item(row);
  endtask

  // voxel size written only once the block has drained
  task automatic set_edge(logic [SIZE_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    edge_len = v;
    sizes_used++;
  endtask

  // coordinate near a few voxel edges, or anywhere at all
  function automatic logic signed [COORD_W-1:0] pick_coord();
    longint c;
    if ($urandom_range(99) < 35) return $urandom;
    c = (longint'($urandom_range(8)) - 4) * longint'((edge_len == 0) ? 1 : edge_len);
    c = c + longint'($urandom_range(3)) - 1;
    return c[COORD_W-1:0];
  endfunction

  // about n input transfers of mixed traffic
  task automatic random_phase(int n);
    int roll;
    int stop;
    stop = items_sent + n;
    while (items_sent < stop) begin
      roll = $urandom_range(99);
      if (held_count > 48 || roll < 5) add_point(ACT_CLEAR, $urandom, $urandom, $urandom);
      else if (roll < 8) add_point(ACT_UNUSED, $urandom, $urandom, $urandom);
      else if (roll < 60) add_point(ACT_ADD, pick_coord(), pick_coord(), pick_coord());
      else if (roll < 66) begin
        // walk the rest of the table from the read pointer and one past its end
        repeat (held_count - walk_pos + 1) add_point(ACT_READ, $urandom, $urandom, $urandom);
      end
      else add_point(ACT_READ, $urandom, $urandom, $urandom);
    end
  endtask

  // result side: check each transfer, then choose the next ready
  always @(posedge clk) begin
    voxel_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer, status %0d", out_ch.status);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status || out_ch.out_x !== want.x ||
              out_ch.out_y !== want.y || out_ch.out_z !== want.z ||
              out_ch.kept_count !== want.count || out_ch.last_kept !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d x %h y %h z %h cnt %0d last %0d,",
                       want.status, want.x, want.y, want.z, want.count, want.last,
                       " got st %0d x %h y %h z %h cnt %0d last %0d",
                       out_ch.status, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                       out_ch.kept_count, out_ch.last_kept);
          end
        end
      end
      out_ch.ready <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  initial begin
    #20_000_000;
    $display("voxel_grid_first_point_filter test failed");
    $finish;
  end

  initial begin
    directed_row_t rows [20];
    rows[0]  = '{ACT_READ,   0, 0, 0, 1'b1, ST_PAST_END, 0};
    rows[1]  = '{ACT_CLEAR,  0, 0, 0, 1'b1, ST_CLEARED,  0};
    rows[2]  = '{ACT_UNUSED, 32'h7fffffff, 0, 0, 1'b1, ST_PAST_END, 0};
    rows[3]  = '{ACT_ADD,    0, 0, 0, 1'b1, ST_KEPT, 1};
    rows[4]  = '{ACT_ADD,    32'h0000ffff, 32'h0000ffff, 32'h0000ffff, 1'b1, ST_DUP, 1};
    rows[5]  = '{ACT_ADD,    -1, -1, -1, 1'b1, ST_KEPT, 2};
    rows[6]  = '{ACT_ADD,    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, ST_KEPT, 3};
    rows[7]  = '{ACT_ADD,    32'h80000000, 32'h80000000, 32'h80000000, 1'b1, ST_KEPT, 4};
    rows[8]  = '{ACT_ADD,    32'h80000000, 32'h7fffffff, 0, 1'b0, 0, 0};
    rows[9]  = '{ACT_ADD,    0, 32'hffff0000, 32'h00010000, 1'b0, 0, 0};
    rows[10] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[11] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    // add while reading: this point falls in a voxel already held, so it is a duplicate
    rows[12] = '{ACT_ADD,    32'h80000001, 32'h80000000, 32'h80000000, 1'b0, 0, 0};
    rows[13] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[14] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[15] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[16] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[17] = '{ACT_READ,   0, 0, 0, 1'b0, 0, 0};
    rows[18] = '{ACT_CLEAR,  0, 0, 0, 1'b1, ST_CLEARED, 0};
    rows[19] = '{ACT_READ,   0, 0, 0, 1'b1, ST_PAST_END, 0};

    held_count = 0;
    walk_pos = 0;
    edge_len = VOXEL_SIZE_RESET;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    sizes_used = 1;
    idle_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i]);

    // random traffic over a spread of voxel sizes, one stretch without idling
    random_phase(150);
    set_edge(SIZE_W'(1));
    random_phase(100);
    set_edge('0);
    random_phase(80);
    set_edge({SIZE_W{1'b1}});
    idle_on = 1'b0;
    random_phase(130);
    idle_on = 1'b1;
    set_edge(SIZE_W'($urandom_range(1, 32'h0004_0000)));
    random_phase(140);
    set_edge(SIZE_W'($urandom));
    random_phase(110);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d items over %0d voxel sizes, %0d results checked",
             items_sent, sizes_used, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("voxel_grid_first_point_filter test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("voxel_grid_first_point_filter test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/vgf_pkg.sv
src/vgf_in_if.sv
src/vgf_out_if.sv
src/voxel_grid_first_point_filter.sv
src/vgf_checker.sv
bench/tb_voxel_grid_first_point_filter.sv
